/* rtl/oled_text_framebuffer_renderer_assert.svh */
// Assertion macros shared by the renderer modules.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef OLED_TEXT_FRAMEBUFFER_RENDERER_ASSERT_SVH
`define OLED_TEXT_FRAMEBUFFER_RENDERER_ASSERT_SVH

// same-cycle implication
`define OTFR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// next-cycle implication
`define OTFR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

/* rtl/otfr_pkg.sv */
`timescale 1ns / 1ps

package otfr_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int GLYPH_COUNT = 103;

  localparam logic [1:0] CMD_DRAW = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_MERGE = 2'd3;

  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd134;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] char_code;
    logic       dbl_glyph;
    logic       color;
    logic [9:0] read_index;
  } otfr_in_t;

  typedef struct packed {
    logic       drawn;
    logic [7:0] read_data;
  } otfr_out_t;

  // one frame store access per cycle
  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        bits;
    logic              white;
  } otfr_req_t;

  // six column bytes per glyph, leftmost column in the top byte
  localparam logic [47:0] GLYPH_ROM [GLYPH_COUNT] = '{
    48'h000000000000, 48'h0000002f0000, 48'h000007000700, 48'h00147f147f14,
    48'h00242a7f2a12, 48'h006264081323, 48'h003649552250, 48'h000005030000,
    48'h00001c224100, 48'h000041221c00, 48'h0014083E0814, 48'h0008083E0808,
    48'h000000A06000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
    48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h000056360000,
    48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
    48'h00324959513E, 48'h007C1211127C, 48'h007F49494936, 48'h003E41414122,
    48'h007F4141221C, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
    48'h007F0808087F, 48'h0000417F4100, 48'h002040413F01, 48'h007F08142241,
    48'h007F40404040, 48'h007F020C027F, 48'h007F0408107F, 48'h003E4141413E,
    48'h007F09090906, 48'h003E4151215E, 48'h007F09192946, 48'h004649494931,
    48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F,
    48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007F414100,
    48'h00552A552A55, 48'h000041417F00, 48'h000402010204, 48'h004040404040,
    48'h000001020400, 48'h002054545478, 48'h007F48444438, 48'h003844444420,
    48'h00384444487F, 48'h003854545418, 48'h00087E090102, 48'h0018A4A4A47C,
    48'h007F08040478, 48'h0000447D4000, 48'h004080847D00, 48'h007F10284400,
    48'h0000417F4000, 48'h007C04180478, 48'h007C08040478, 48'h003844444438,
    48'h00FC24242418, 48'h0018242418FC, 48'h007C08040408, 48'h004854545420,
    48'h00043F444020, 48'h003C4040207C, 48'h001C2040201C, 48'h003C4030403C,
    48'h004428102844, 48'h001CA0A0A07C, 48'h004464544C44, 48'h000008774100,
    48'h000000630000, 48'h000041770800, 48'h000804080804, 48'h003D4040207D,
    48'h003D4040403D, 48'h002154545479, 48'h007D1211127D, 48'h003944444439,
    48'h003D4242423D, 48'h000205020000, 48'h007E01495573
  };

  function automatic logic [7:0] remap_code(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'd252:  r = 8'd127;
      8'd220:  r = 8'd128;
      8'd228:  r = 8'd129;
      8'd196:  r = 8'd130;
      8'd246:  r = 8'd131;
      8'd214:  r = 8'd132;
      8'd176:  r = 8'd133;
      8'd223:  r = 8'd134;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glyph_col(input logic [47:0] g, input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = g[47:40];
      3'd1:    b = g[39:32];
      3'd2:    b = g[31:24];
      3'd3:    b = g[23:16];
      3'd4:    b = g[15:8];
      3'd5:    b = g[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // bits 0..6 doubled vertically
  function automatic logic [13:0] double_bits(input logic [7:0] b);
    logic [13:0] w;
    w = '0;
    for (int i = 0; i < 7; i++) begin
      w[2*i]   = b[i];
      w[2*i+1] = b[i];
    end
    return w;
  endfunction

endpackage

/* rtl/otfr_store.sv */
`timescale 1ns / 1ps
`include "oled_text_framebuffer_renderer_assert.svh"

module otfr_store import otfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  otfr_req_t req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] mem_q_r;

  logic              pend_r;
  logic [ADDR_W-1:0] p_addr_r;
  logic [7:0]        p_bits_r;
  logic              p_white_r;

  logic              last_v_r;
  logic [ADDR_W-1:0] last_addr_r;
  logic [7:0]        last_data_r;

  logic [7:0]        old_byte;
  logic [7:0]        merged;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // merge write of the previous cycle is not yet in mem_q_r
  always_comb begin
    old_byte = (last_v_r && (last_addr_r == p_addr_r)) ? last_data_r : mem_q_r;
    merged   = p_white_r ? (old_byte | p_bits_r) : (old_byte & ~p_bits_r);
    wr_en    = pend_r || (req.kind == REQ_WRITE);
    wr_addr  = pend_r ? p_addr_r : req.addr;
    wr_data  = pend_r ? merged : req.bits;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      last_v_r <= 1'b0;
    end else begin
      pend_r   <= (req.kind == REQ_MERGE);
      last_v_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    p_addr_r    <= req.addr;
    p_bits_r    <= req.bits;
    p_white_r   <= req.white;
    last_addr_r <= p_addr_r;
    last_data_r <= merged;
  end

  assign rd_data = mem_q_r;

  `OTFR_ASSERT_IMP(a_no_write_clash, pend_r, req.kind != REQ_WRITE)
  `OTFR_ASSERT_IMP(a_white_sets, pend_r && p_white_r, (wr_data & p_bits_r) == p_bits_r)
  `OTFR_ASSERT_IMP(a_black_clears, pend_r && !p_white_r, (wr_data & p_bits_r) == 8'h00)
  `OTFR_ASSERT_NXT(a_merge_follows, req.kind == REQ_MERGE, pend_r && wr_en)

endmodule

/* rtl/oled_text_framebuffer_renderer.sv */
`timescale 1ns / 1ps
`include "oled_text_framebuffer_renderer_assert.svh"
// Channel  Ports                 Transaction
// -------  --------------------  -------------------------------------------
// in       start, busy, in_data  taken at a clock edge with start=1, busy=0
// out      out_valid, out_data   one-cycle strobe per command, no stall
//
// After reset every byte of the frame store is cleared; busy is high then.
// Draw: up to 12 (normal) or 48 (double size) read-modify-write transactions
// on the frame store, one per cycle through its read and write port; a step off
// the screen or store makes none. Fill: one write per used store byte.
// A rejected draw or an unused command answers in the cycle after it is taken.
// The result strobe cannot be held off; busy blocks new commands meanwhile.

module oled_text_framebuffer_renderer import otfr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  otfr_in_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output otfr_out_t out_data
);

  localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
  localparam int RAW_SIZE   = PAGE_COUNT * SCREEN_WIDTH;
  localparam int USED_SIZE  = (RAW_SIZE < STORE_DEPTH) ? RAW_SIZE : STORE_DEPTH;
  localparam int IDX_W      = 15;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  logic [2:0]        state_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [7:0]        x_r;
  logic [7:0]        y_r;
  logic              dbl_r;
  logic              white_r;
  logic [47:0]       glyph_r;
  logic [2:0]        k_r;
  logic [2:0]        sub_r;

  logic              a_v_r;
  logic              a_ok_r;
  logic [ADDR_W-1:0] a_addr_r;
  logic [7:0]        a_bits_r;

  logic              out_valid_r;
  otfr_out_t         out_data_r;

  otfr_req_t         req;
  logic [7:0]        rd_data;

  logic [7:0]        rc;
  logic [6:0]        glyph_idx;
  logic              draw_ok;

  logic [1:0]        p;
  logic              half;
  logic [3:0]        off;
  logic [8:0]        col9;
  logic [8:0]        row9;
  logic [7:0]        gbyte;
  logic [13:0]       dw;
  logic [7:0]        bits;
  logic [15:0]       wide;
  logic [7:0]        part;
  logic [IDX_W-1:0]  idx;
  logic              on_store;
  logic              last_step;

  assign busy = !rst_n || (state_r != ST_IDLE);

  always_comb begin
    rc        = remap_code(in_data.char_code);
    glyph_idx = 7'(rc - CODE_FIRST);
    draw_ok   = ({1'b0, in_data.pos_x} < 9'(SCREEN_WIDTH)) &&
                ({1'b0, in_data.pos_y} < 9'(SCREEN_HEIGHT)) &&
                (rc >= CODE_FIRST) && (rc <= CODE_LAST);
  end

  // column access generator
  always_comb begin
    p     = sub_r[2:1];
    half  = sub_r[0];
    off   = dbl_r ? ({k_r, 1'b0} + {3'b000, p[1]}) : {1'b0, k_r};
    col9  = {1'b0, x_r} + {5'b00000, off};
    row9  = {1'b0, y_r} + {5'b00000, dbl_r & p[0], 3'b000};
    gbyte = glyph_col(glyph_r, k_r);
    dw    = double_bits(gbyte);
    if (dbl_r) begin
      bits = p[0] ? {2'b00, dw[13:8]} : dw[7:0];
    end else begin
      bits = gbyte;
    end
    wide  = {8'h00, bits} << row9[2:0];
    part  = half ? wide[15:8] : wide[7:0];
    idx   = IDX_W'(row9[8:3]) * IDX_W'(SCREEN_WIDTH) + IDX_W'(col9) +
            (half ? IDX_W'(SCREEN_WIDTH) : IDX_W'(0));
    on_store  = (col9 < 9'(SCREEN_WIDTH)) && (row9 < 9'(SCREEN_HEIGHT)) &&
                (idx < IDX_W'(USED_SIZE));
    last_step = (k_r == 3'd5) && (sub_r == (dbl_r ? 3'd7 : 3'd1));
  end

  always_comb begin
    req.kind  = REQ_NONE;
    req.addr  = a_addr_r;
    req.bits  = a_bits_r;
    req.white = white_r;
    unique case (state_r)
      ST_INIT: begin
        req.kind = REQ_WRITE;
        req.addr = sweep_r;
        req.bits = 8'h00;
      end
      ST_FILL: begin
        req.kind = REQ_WRITE;
        req.addr = sweep_r;
        req.bits = {8{white_r}};
      end
      ST_IDLE: begin
        if (start && (in_data.cmd == CMD_READ)) begin
          req.kind = REQ_READ;
          req.addr = in_data.read_index;
        end
      end
      ST_DRAW, ST_DRAIN: begin
        if (a_v_r && a_ok_r) begin
          req.kind = REQ_MERGE;
        end
      end
      default: req.kind = REQ_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      a_v_r       <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      a_v_r       <= (state_r == ST_DRAW);
      unique case (state_r)
        ST_INIT: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == ADDR_W'(STORE_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            unique case (in_data.cmd)
              CMD_DRAW: begin
                if (draw_ok) begin
                  x_r     <= in_data.pos_x;
                  y_r     <= in_data.pos_y;
                  dbl_r   <= in_data.dbl_glyph;
                  white_r <= in_data.color;
                  glyph_r <= GLYPH_ROM[glyph_idx];
                  k_r     <= '0;
                  sub_r   <= '0;
                  state_r <= ST_DRAW;
                end else begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= '0;
                end
              end
              CMD_FILL: begin
                white_r <= in_data.color;
                sweep_r <= '0;
                state_r <= ST_FILL;
              end
              CMD_READ: state_r <= ST_READ;
              default: begin
                out_valid_r <= 1'b1;
                out_data_r  <= '0;
              end
            endcase
          end
        end
        ST_DRAW: begin
          if (last_step) begin
            state_r <= ST_DRAIN;
          end else if (sub_r == (dbl_r ? 3'd7 : 3'd1)) begin
            sub_r <= '0;
            k_r   <= k_r + 1'b1;
          end else begin
            sub_r <= sub_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!a_v_r) begin
            out_valid_r          <= 1'b1;
            out_data_r.drawn     <= 1'b1;
            out_data_r.read_data <= 8'h00;
            state_r              <= ST_IDLE;
          end
        end
        ST_FILL: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == ADDR_W'(USED_SIZE - 1)) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            state_r     <= ST_IDLE;
          end
        end
        ST_READ: begin
          out_valid_r          <= 1'b1;
          out_data_r.drawn     <= 1'b0;
          out_data_r.read_data <= rd_data;
          state_r              <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_ok_r   <= on_store;
    a_addr_r <= idx[ADDR_W-1:0];
    a_bits_r <= part;
  end

  otfr_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `OTFR_ASSERT_IMP(a_drawn_after_drain, out_valid && out_data.drawn,
                   $past(state_r) == ST_DRAIN)
  `OTFR_ASSERT_IMP(a_data_from_read, out_valid && (out_data.read_data != 8'h00),
                   $past(state_r) == ST_READ)
  `OTFR_ASSERT_IMP(a_gen_in_draw, a_v_r, (state_r == ST_DRAW) || (state_r == ST_DRAIN))
  `OTFR_ASSERT_IMP(a_read_latency,
                   $past(rst_n) && $past(start && !busy && (in_data.cmd == CMD_READ), 2),
                   out_valid)

endmodule
